@@ rtl/light_smoothstep_fader_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the light fader checker
// Macros expect signals named clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SMOOTHSTEP_FADER_DEFINES_SVH
`define LIGHT_SMOOTHSTEP_FADER_DEFINES_SVH

// same-cycle implication
`define LSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("light fader check failed");

// next-cycle implication
`define LSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("light fader check failed");

`endif

@@ rtl/lsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants and the per-light record of the smoothstep fader.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int NUM_LIGHTS = 8;
  localparam int POS_W      = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
  localparam int IDX_W      = 3;
  localparam int CMP_W      = (POS_W > IDX_W) ? POS_W : IDX_W;
  localparam int LEVEL_W    = 15;
  localparam int TIME_W     = 32;
  localparam int FRAC_W     = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd16384;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] start;
    logic [LEVEL_W-1:0] target;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  length;
  } light_rec_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/lsf_cell.sv @@
// ----------------------------------------------------------------------------
// lsf_cell
// One link of the light ring: holds a light record, takes its neighbour's.
// ----------------------------------------------------------------------------
module lsf_cell
  import lsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rot,
  input  light_rec_t din,
  output light_rec_t q
);

  light_rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (rot) begin
      rec <= din;
    end
  end

  assign q = rec;

endmodule

@@ rtl/lsf_div.sv @@
// ----------------------------------------------------------------------------
// lsf_div
// Restoring divider: floor(num * 2^16 / den) for num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module lsf_div
  import lsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] den;
  logic [FRAC_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic              done;
  logic [TIME_W:0]   sh;
  logic [TIME_W:0]   diff;

  assign sh   = {rem, 1'b0};
  assign diff = sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= req.num;
        den <= req.den;
        cnt <= CNT_W'(FRAC_W);
      end else if (cnt != '0) begin
        if (!diff[TIME_W]) begin
          rem <= diff[TIME_W-1:0];
        end else begin
          rem <= sh[TIME_W-1:0];
        end
        quo <= {quo[FRAC_W-2:0], ~diff[TIME_W]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ rtl/light_smoothstep_fader.sv @@
// ----------------------------------------------------------------------------
// light_smoothstep_fader
// Bank of light channels fading along a smoothstep curve.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one request (set or tick). Output
// channel: out_valid / out_stall carry one result per request, reporting
// light_level and fading of the light named by light_index.
// The light records sit in a ring of cells; a request walks the whole ring,
// one light at a time through the head cell. A light that needs no
// arithmetic passes S_STEP and S_ROT; a fading light on a tick also waits
// in S_DIV for the divider and passes three multiply steps before S_ROT.
// One request is worked on at a time; in_stall is high while it is.
// The result waits in an output register; the next request may be taken
// while it waits, and its own result holds until the receiver takes the
// first. Reset zeroes every light and empties the output register.
// ----------------------------------------------------------------------------
module light_smoothstep_fader
  import lsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [IDX_W-1:0]     light_index,
  input  logic [15:0]          target_intensity,
  input  logic [TIME_W-1:0]    fade_duration_us,
  input  logic [TIME_W-1:0]    tick_elapsed_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LEVEL_W-1:0]   light_level,
  output logic                 fading
);

  typedef enum logic [2:0] {
    S_IDLE, S_STEP, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_ROT, S_FINISH
  } state_t;

  state_t state;

  logic               r_tick;
  logic [IDX_W-1:0]   r_idx;
  logic [LEVEL_W-1:0] r_want;
  logic [TIME_W-1:0]  r_dur;
  logic [TIME_W-1:0]  r_dt;
  logic [POS_W-1:0]   pos;
  light_rec_t         upd;
  logic [FRAC_W-1:0]  p;
  logic [FRAC_W-1:0]  p2;
  logic [FRAC_W:0]    eased;
  logic [LEVEL_W-1:0] res_level;
  logic               res_fading;
  logic               res_hit;

  light_rec_t cell_q [NUM_LIGHTS];
  light_rec_t head;
  logic       rot;
  logic       match;
  logic [TIME_W:0]   esum;
  logic [TIME_W-1:0] e_sat;
  logic              need_div;
  light_rec_t        step_rec;
  div_req_t          dreq;
  div_rsp_t          drsp;
  logic              up;
  logic [LEVEL_W-1:0] mdiff;
  logic [32:0]        mag_full;
  logic [LEVEL_W-1:0] mag;
  logic [33:0]        e_prod;
  logic [17:0]        three_m;

  assign rot  = (state == S_ROT);
  assign head = cell_q[0];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_LIGHTS; gi++) begin : g_ring
      lsf_cell u_cell (
        .clk (clk),
        .rst (rst),
        .rot (rot),
        .din ((gi == NUM_LIGHTS - 1) ? upd : cell_q[(gi + 1) % NUM_LIGHTS]),
        .q   (cell_q[gi])
      );
    end
  endgenerate

  assign match = (CMP_W'(pos) == CMP_W'(r_idx));
  assign esum  = {1'b0, head.elapsed} + {1'b0, r_dt};
  assign e_sat = esum[TIME_W] ? '1 : esum[TIME_W-1:0];

  // work out the head light's new record, bar the eased level
  always_comb begin
    step_rec = head;
    need_div = 1'b0;
    if (r_tick) begin
      if (head.length != '0) begin
        step_rec.elapsed = e_sat;
        if (e_sat >= head.length) begin
          step_rec.level  = head.target;
          step_rec.length = '0;
        end else begin
          need_div = 1'b1;
        end
      end
    end else if (match) begin
      if (r_dur == '0 || r_want == head.level) begin
        step_rec.level   = r_want;
        step_rec.start   = r_want;
        step_rec.target  = r_want;
        step_rec.elapsed = '0;
        step_rec.length  = '0;
      end else begin
        step_rec.start   = head.level;
        step_rec.target  = r_want;
        step_rec.elapsed = '0;
        step_rec.length  = r_dur;
      end
    end
  end

  assign dreq.start = (state == S_STEP) && need_div;
  assign dreq.num   = e_sat;
  assign dreq.den   = head.length;

  lsf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign three_m  = 18'd196608 - {1'b0, p, 1'b0};
  assign e_prod   = {16'd0, p2} * {16'd0, three_m};
  assign up       = (upd.target >= upd.start);
  assign mdiff    = up ? (upd.target - upd.start) : (upd.start - upd.target);
  assign mag_full = {18'd0, mdiff} * {16'd0, eased}
                    + (up ? 33'd0 : 33'd65535);
  assign mag      = mag_full[FRAC_W +: LEVEL_W];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      res_hit   <= 1'b0;
    end else begin
      // drop a taken result unless a new one replaces it this cycle
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_tick  <= req_type;
            r_idx   <= light_index;
            r_want  <= (target_intensity > 16'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : target_intensity[LEVEL_W-1:0];
            r_dur   <= fade_duration_us;
            r_dt    <= tick_elapsed_us;
            pos     <= '0;
            res_hit <= 1'b0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          upd   <= step_rec;
          state <= need_div ? S_DIV : S_ROT;
        end
        S_DIV: begin
          if (drsp.done) begin
            p     <= drsp.quo;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p2    <= 16'(({16'd0, p} * {16'd0, p}) >> FRAC_W);
          state <= S_MUL2;
        end
        S_MUL2: begin
          eased <= e_prod[FRAC_W +: FRAC_W + 1];
          state <= S_MUL3;
        end
        S_MUL3: begin
          upd.level <= up ? (upd.start + mag) : (upd.start - mag);
          state     <= S_ROT;
        end
        S_ROT: begin
          if (match) begin
            res_hit    <= 1'b1;
            res_level  <= upd.level;
            res_fading <= (upd.length != '0);
          end
          if (pos == POS_W'(NUM_LIGHTS - 1)) begin
            state <= S_FINISH;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_STEP;
          end
        end
        S_FINISH: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            light_level <= res_hit ? res_level : '0;
            fading      <= res_hit & res_fading;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/lsf_checker.sv @@
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks on the light fader, bound to the top level.
// ----------------------------------------------------------------------------
`include "light_smoothstep_fader_defines.svh"

module lsf_checker
  import lsf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] light_level,
  input logic               fading
);

  `LSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LSF_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(light_level) && $stable(fading))
  `LSF_ASSERT_NOW(a_level_range, out_valid, light_level <= LEVEL_MAX)
  `LSF_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall && !(out_valid && !$past(out_valid)))

endmodule

bind light_smoothstep_fader lsf_checker u_lsf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .light_level (light_level),
  .fading      (fading)
);
